### sv/fbs_pkg.sv
package fbs_pkg;

	localparam int WORD_BITS  = 32;
	localparam int INDEX_BITS = 32;
	localparam int OUT_BITS   = 32;
	// a negative index is loaded as zero, so the sign bit is not walked
	localparam int N_BITS     = INDEX_BITS - 1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [N_BITS-1:0]    nbits_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic add_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

### sv/fbs_dp.sv
module fbs_dp (
	input  logic                            clk,
	input  fbs_pkg::cmd_t                   cmd,
	input  logic [fbs_pkg::INDEX_BITS-1:0]  index,
	output fbs_pkg::status_t                status,
	output logic [fbs_pkg::OUT_BITS-1:0]    fib_value
);
	import fbs_pkg::*;

	nbits_t n_q;
	word_t  i_q, j_q, k_q, h_q;
	word_t  p_jh_q, p_ih_q, p_jk_q, p_ik_q, p_hh_q, p_kh_q, p_kk_q;
	logic [OUT_BITS-1:0] fib_value_q;

	// low half of each product is all that matters, everything wraps
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			p_jh_q <= j_q * h_q;
			p_ih_q <= i_q * h_q;
			p_jk_q <= j_q * k_q;
			p_ik_q <= i_q * k_q;
			p_hh_q <= h_q * h_q;
			p_kh_q <= k_q * h_q;
			p_kk_q <= k_q * k_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= index[INDEX_BITS-1] ? '0 : index[N_BITS-1:0];
			i_q <= word_t'(1);
			j_q <= '0;
			k_q <= '0;
			h_q <= word_t'(1);
		end else if (cmd.add_en) begin
			// fold the current power into the accumulator when the bit is set
			if (n_q[0]) begin
				j_q <= p_ih_q + p_jk_q + p_jh_q;
				i_q <= p_ik_q + p_jh_q;
			end
			h_q <= (p_kh_q << 1) + p_hh_q;
			k_q <= p_kk_q + p_hh_q;
			n_q <= n_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			fib_value_q <= OUT_BITS'(j_q);
		end
	end

	assign status.last = (n_q[N_BITS-1:1] == '0);
	assign fib_value   = fib_value_q;

endmodule

### sv/fbs_ctrl.sv
module fbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             index_valid,
	output logic             index_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  fbs_pkg::status_t status,
	output fbs_pkg::cmd_t    cmd
);
	import fbs_pkg::*;

	state_t state_q, state_d;
	logic   result_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (index_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = status.last ? ST_FIN : ST_MUL;
			end
			ST_FIN: begin
				if (!result_valid_q || !result_stall) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		index_stall  = (state_q != ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && index_valid;
		cmd.mul_en   = (state_q == ST_MUL);
		cmd.add_en   = (state_q == ST_ADD);
		// output slot is free when empty or being taken this cycle
		cmd.out_load = (state_q == ST_FIN) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(index_valid && !index_stall) |=> (state_q == ST_MUL))
		else $error("accepted item did not start the multiply phase");

	a_mul_then_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_ADD))
		else $error("multiply phase not followed by add phase");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid_q || !result_stall))
		else $error("result register overwritten while stalled");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result valid raised outside the finish state");
`endif

endmodule

### sv/fibonacci_by_squaring.sv
// one iteration per significant bit of the index (at least one, so one for an index <= 0):
// a multiply state on seven shared 32x32 multipliers, then an add state
// a new index is accepted only once the previous result is loaded, later while a
// stalled result still holds the output register
// arst_n clears the controller and the result valid flag; data registers are not reset
module fibonacci_by_squaring (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            index_valid,
	output logic                            index_stall,
	input  logic [fbs_pkg::INDEX_BITS-1:0]  index,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [fbs_pkg::OUT_BITS-1:0]    fib_value
);
	import fbs_pkg::*;

	cmd_t    cmd;
	status_t status;

	fbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.index_valid  (index_valid),
		.index_stall  (index_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	fbs_dp u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.index     (index),
		.status    (status),
		.fib_value (fib_value)
	);

endmodule

### bench/fibonacci_by_squaring_tb.sv
module fibonacci_by_squaring_tb;
	import fbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 80;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  index_valid  = 1'b0;
	logic                  index_stall;
	logic [INDEX_BITS-1:0] index        = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [OUT_BITS-1:0]   fib_value;

	typedef struct {
		logic [INDEX_BITS-1:0] n;
		logic [OUT_BITS-1:0]   f;
	} fib_pending_t;

	fib_pending_t fib_expected[$];

	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	int mismatches   = 0;
	int indexes_sent = 0;
	int nonpos_sent  = 0;
	int fibs_checked = 0;
	int quiet_cycles = 0;

	fibonacci_by_squaring dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.index_valid  (index_valid),
		.index_stall  (index_stall),
		.index        (index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.fib_value    (fib_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// matrix squaring over the index bits, lsb first, every term wraps at the word width
	function automatic logic [OUT_BITS-1:0] fib_mod_word(input logic [INDEX_BITS-1:0] n);
		word_t                 acc_i, acc_j, pk, ph, t;
		logic [INDEX_BITS-1:0] rest;
		acc_i = 1;
		acc_j = 0;
		pk    = 0;
		ph    = 1;
		if (n[INDEX_BITS-1])
			return '0;
		rest = n;
		while (rest != 0) begin
			if (rest[0]) begin
				t     = acc_j * ph;
				acc_j = acc_i * ph + acc_j * pk + t;
				acc_i = acc_i * pk + t;
			end
			t    = ph * ph;
			ph   = 2 * pk * ph + t;
			pk   = pk * pk + t;
			rest = rest >> 1;
		end
		return acc_j[OUT_BITS-1:0];
	endfunction

	// mostly short indexes so the run stays fast, a few longer ones up to full length, some zero or negative
	function automatic logic [INDEX_BITS-1:0] random_index();
		int                    pick;
		int                    len;
		logic [INDEX_BITS-1:0] v;
		pick = $urandom_range(99);
		v    = $urandom;
		if (pick < 8) begin
			v[INDEX_BITS-1] = 1'b1;
		end else if (pick < 12) begin
			v = '0;
		end else begin
			len = (pick < 85) ? $urandom_range(1, 12) : $urandom_range(13, INDEX_BITS - 1);
			v   = v & ((32'h1 << len) - 1);
			v[len-1] = 1'b1;
		end
		return v;
	endfunction

	task automatic report_mismatch(input logic [INDEX_BITS-1:0] n,
			input logic [OUT_BITS-1:0] got, input logic [OUT_BITS-1:0] want);
		$display("mismatch: index %0d (0x%08h) fib_value 0x%08h, wanted 0x%08h",
			$signed(n), n, got, want);
		mismatches++;
	endtask

	// valid stays high after acceptance so a following item goes out back to back
	task automatic send_index(input logic [INDEX_BITS-1:0] n);
		fib_pending_t p;
		if (send_idle_on && $urandom_range(99) < 14) begin
			index_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		index_valid <= 1'b1;
		index       <= n;
		do
			@(posedge clk);
		while (index_stall);
		p.n = n;
		p.f = fib_mod_word(n);
		fib_expected.push_back(p);
		indexes_sent++;
		if (n == 0 || n[INDEX_BITS-1])
			nonpos_sent++;
	endtask

	task automatic wait_drained();
		index_valid <= 1'b0;
		wait (fib_expected.size() == 0);
		@(posedge clk);
	endtask

	task automatic test_directed();
		logic [INDEX_BITS-1:0] list[$];
		list = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd10, 32'd46, 32'd47, 32'd48, 32'd93,
			32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000,
			32'd255, 32'd256, 32'd65535, 32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA,
			32'h0000_8001};
		foreach (list[i])
			send_index(list[i]);
	endtask

	task automatic test_random(input int count);
		repeat (count)
			send_index(random_index());
	endtask

	task automatic test_back_to_back(input int count);
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		repeat (count)
			send_index(random_index());
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	// sender holds off until every item in flight has come back, then resumes
	task automatic test_drain_pause(input int count);
		repeat (count)
			send_index(random_index());
		wait_drained();
		repeat (count)
			send_index(random_index());
	endtask

	always @(posedge clk) begin
		fib_pending_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (fib_expected.size() == 0) begin
				$display("unexpected item: fib_value 0x%08h with nothing pending", fib_value);
				mismatches++;
			end else begin
				want = fib_expected.pop_front();
				fibs_checked++;
				if (fib_value !== want.f)
					report_mismatch(want.n, fib_value, want.f);
			end
		end
		result_stall <= recv_idle_on && ($urandom_range(99) < 14);
	end

	always @(posedge clk) begin
		if (!arst_n || (index_valid && !index_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles, %0d pending",
				WATCHDOG_LIMIT, fib_expected.size());
			$display("fibonacci_by_squaring_tb: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_drain_pause(20);
		test_back_to_back(150);
		test_random(400);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d indexes (%0d zero or negative), %0d results checked, %0d mismatches",
			indexes_sent, nonpos_sent, fibs_checked, mismatches);
		$display("included a back-to-back stretch with no idling and a full drain pause");
		if (mismatches == 0 && fib_expected.size() == 0)
			$display("fibonacci_by_squaring_tb: PASS");
		else
			$display("fibonacci_by_squaring_tb: FAIL");
		$finish;
	end

endmodule
